// File: rtl/tbhp_pkg.sv
`default_nettype none

package tbhp_pkg;

	localparam int unsigned PC_W = 32;
	localparam int unsigned IDX_LSB = 3;
	localparam int unsigned TABLE_ENTRIES_DEF = 64;

	typedef enum logic [1:0] {
		MODE_STATIC = 2'd0,
		MODE_ONE_BIT = 2'd1,
		MODE_TWO_BIT = 2'd2,
		MODE_ALLOC_ONLY = 2'd3
	} mode_t;

	typedef struct packed {
		logic [PC_W-1:0] branch_pc;
		logic taken;
	} in_t;

	typedef struct packed {
		logic predict_taken;
		logic tag_hit;
		logic mispredict;
	} out_t;

endpackage

`default_nettype wire

// File: rtl/tbhp_ram.sv
`default_nettype none

module tbhp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read-first: a same-address write in this cycle is not seen
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/tagged_branch_history_predictor.sv
// order: an accepted beat passes stage s1 with the ram read, then out_data
// throughput: one branch per cycle unless out_ready stalls; the table
//   read-modify-write spans registered ram read and write-back, with neighbor forwarding
// reset: valid bits, mode (always not taken) and handshake state clear at once;
//   tag and history storage is not cleared, an invalid entry reads as empty
`default_nettype none

module tagged_branch_history_predictor
	import tbhp_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_data
);

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned TAG_LSB = IDX_LSB + IDX_W;
	localparam int unsigned TAG_W = PC_W - IDX_W;
	localparam int unsigned ENT_W = TAG_W + 2;

	mode_t mode_q;

	logic s1_valid;
	logic [IDX_W-1:0] idx_s1;
	logic [TAG_W-1:0] tag_s1;
	logic taken_s1;
	logic fwd_s1;
	logic [ENT_W-1:0] fwd_data_s1;

	logic [TABLE_ENTRIES-1:0] vld_q;

	logic accept;
	logic advance;
	logic [IDX_W-1:0] in_idx;
	logic [ENT_W-1:0] ram_rdata;
	logic [ENT_W-1:0] entry;
	logic entry_valid;
	logic hit;
	logic [1:0] h_rd;
	logic [1:0] h_new;
	logic pred;
	logic wr_en;
	logic [ENT_W-1:0] wr_data;

	assign cfg_ready = 1'b1;

	assign advance = s1_valid && (!out_valid || out_ready);
	assign in_ready = !s1_valid || advance;
	assign accept = in_valid && in_ready;
	assign in_idx = in_data.branch_pc[IDX_LSB +: IDX_W];

	assign entry = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign entry_valid = vld_q[idx_s1];
	assign hit = entry_valid && (entry[ENT_W-1:2] == tag_s1);
	// an entry never allocated reads as a history of zero
	assign h_rd = entry_valid ? entry[1:0] : 2'b00;

	always_comb begin
		pred = 1'b0;
		h_new = h_rd;
		wr_en = 1'b1;
		unique case (mode_q)
			MODE_STATIC: begin
				wr_en = 1'b0;
			end
			MODE_ONE_BIT: begin
				pred = hit & h_rd[1];
				h_new = {taken_s1, h_rd[0]};
			end
			MODE_TWO_BIT: begin
				pred = hit & h_rd[1];
				h_new[0] = taken_s1;
				if (hit) begin
					if (taken_s1 && h_rd[0]) begin
						h_new[1] = 1'b1;
					end else if (!taken_s1 && !h_rd[0]) begin
						h_new[1] = 1'b0;
					end else begin
						h_new[1] = h_rd[1];
					end
				end else begin
					// a fresh entry starts at 00, so bit 1 stays clear whatever the outcome
					h_new[1] = 1'b0;
				end
			end
			MODE_ALLOC_ONLY: begin
				pred = hit & h_rd[1];
				h_new = hit ? h_rd : 2'b00;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign wr_data = {tag_s1, h_new};

	tbhp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.we(wr_en && advance),
		.waddr(idx_s1),
		.wdata(wr_data),
		.re(accept),
		.raddr(in_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STATIC;
			s1_valid <= 1'b0;
			fwd_s1 <= 1'b0;
			vld_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= mode_t'(cfg_data);
			end
			if (accept) begin
				s1_valid <= 1'b1;
				// the write-back of this cycle misses the ram read, so forward it
				fwd_s1 <= advance && wr_en && (idx_s1 == in_idx);
			end else if (advance) begin
				s1_valid <= 1'b0;
				fwd_s1 <= 1'b0;
			end
			if (advance && wr_en) begin
				vld_q[idx_s1] <= 1'b1;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= in_idx;
			tag_s1 <= {in_data.branch_pc[PC_W-1:TAG_LSB], in_data.branch_pc[IDX_LSB-1:0]};
			taken_s1 <= in_data.taken;
			fwd_data_s1 <= wr_data;
		end
		if (advance) begin
			out_data.predict_taken <= pred;
			out_data.tag_hit <= hit;
			out_data.mispredict <= pred ^ taken_s1;
		end
	end

endmodule

`default_nettype wire
